[sv/assert_macros.svh]
// Assertion macros shared by the blended tilt RTL.
// Needs clk and rst_n in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BTPR_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("blended tilt: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define BTPR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("blended tilt: next-cycle check failed");

`endif

[sv/btpr_pkg.sv]
// Shared widths, register codes, defaults and the CORDIC angle table.
// No dependencies.
`default_nettype none
package btpr_pkg;

    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERR_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ERR_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAV_MIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAV_MAX = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_NORM = 3'd5;

    localparam int THR_W = 15;
    localparam int LIM_W = 16;

    localparam logic [THR_W-1:0] NOMINAL_RST  = 15'd2511;
    localparam logic [THR_W-1:0] ERR_LOW_RST  = 15'd51;
    localparam logic [THR_W-1:0] ERR_HIGH_RST = 15'd384;
    localparam logic [LIM_W-1:0] GRAV_MIN_RST = 16'd2048;
    localparam logic [LIM_W-1:0] GRAV_MAX_RST = 16'd2944;
    localparam logic [LIM_W-1:0] MIN_NORM_RST = 16'd26;

    localparam int VEC_W  = 16;
    localparam int SQ_W   = 31;
    localparam int ASUM_W = 32;
    localparam int MAG_W  = 16;
    localparam int W_W    = 13;
    localparam logic [W_W-1:0] W_ONE = 13'd4096;
    localparam int DIV_STEPS = 12;

    localparam int PROD_W = 30;
    localparam int H_W    = 29;
    localparam int HABS_W = 28;
    localparam int HSQ_W  = 56;
    localparam int HSUM_W = 57;
    localparam int NORM2_W = 32;
    localparam int NORM_SHIFT = 24;

    localparam int SQRT_A_STEPS = ASUM_W / 2;
    localparam int SQRT_H_STEPS = HSQ_W / 2;

    localparam int CORDIC_W = 40;
    localparam int Z_W      = 32;
    localparam int ANGLE_W  = 16;
    localparam int ANGLE_LIMIT = 23040;
    localparam int ATAN_ENTRIES = 24;
    localparam int CORDIC_STAGES_DEF = 16;

    typedef struct packed {
        logic le;
        logic ge;
        logic gout;
    } wflags_t;

    // atan(2^-i) in Q16 degrees.
    function automatic logic signed [Z_W-1:0] atan_q16(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:  v = 32'sd2949120;
            1:  v = 32'sd1740967;
            2:  v = 32'sd919879;
            3:  v = 32'sd466945;
            4:  v = 32'sd234379;
            5:  v = 32'sd117304;
            6:  v = 32'sd58666;
            7:  v = 32'sd29335;
            8:  v = 32'sd14668;
            9:  v = 32'sd7334;
            10: v = 32'sd3667;
            11: v = 32'sd1833;
            12: v = 32'sd917;
            13: v = 32'sd458;
            14: v = 32'sd229;
            15: v = 32'sd115;
            16: v = 32'sd57;
            17: v = 32'sd29;
            18: v = 32'sd14;
            19: v = 32'sd7;
            20: v = 32'sd4;
            21: v = 32'sd2;
            22: v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[sv/btpr_delay.sv]
// Enabled shift line that keeps side data aligned with the main pipeline.
// Uses no package items.
`default_nettype none
module btpr_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  wire logic         clk,
    input  wire logic         en,
    input  wire logic [W-1:0] din,
    output logic      [W-1:0] dout
);
    logic [W-1:0] stage_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                stage_reg[i] <= stage_reg[i-1];
            end
        end
    end

    assign dout = stage_reg[DEPTH-1];
endmodule
`default_nettype wire

[sv/btpr_isqrt.sv]
// Pipelined integer square root, one result bit per register stage.
// Uses no package items.
`default_nettype none
module btpr_isqrt #(
    parameter int IN_W = 32
) (
    input  wire logic                clk,
    input  wire logic                en,
    input  wire logic [IN_W-1:0]     radicand,
    output logic      [IN_W/2-1:0]   root
);
    localparam int OUT_W = IN_W / 2;

    logic [IN_W-1:0]  val_reg  [OUT_W];
    logic [OUT_W+1:0] rem_reg  [OUT_W];
    logic [OUT_W-1:0] root_reg [OUT_W];

    for (genvar s = 0; s < OUT_W; s++)
    begin : g_step
        logic [IN_W-1:0]  val_in;
        logic [OUT_W+1:0] rem_in;
        logic [OUT_W-1:0] root_in;
        logic [OUT_W+1:0] rem_sh;
        logic [OUT_W+1:0] trial;

        if (s == 0)
        begin : g_first
            assign val_in  = radicand;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_next
            assign val_in  = val_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
        end

        // Bring down the next two radicand bits and try root*4 + 1.
        assign rem_sh = {rem_in[OUT_W-1:0], val_in[IN_W-1 -: 2]};
        assign trial  = {root_in, 2'b01};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                val_reg[s] <= val_in << 2;
                if (rem_sh >= trial)
                begin
                    rem_reg[s]  <= rem_sh - trial;
                    root_reg[s] <= {root_in[OUT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[s]  <= rem_sh;
                    root_reg[s] <= {root_in[OUT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign root = root_reg[OUT_W-1];
endmodule
`default_nettype wire

[sv/btpr_div.sv]
// Pipelined restoring divider for the weight ramp: (num << Q_W) / den, num < den.
// Depends on btpr_pkg for the threshold width.
`default_nettype none
module btpr_div #(
    parameter int Q_W = 12
) (
    input  wire logic                    clk,
    input  wire logic                    en,
    input  wire logic [btpr_pkg::THR_W-1:0] num,
    input  wire logic [btpr_pkg::THR_W-1:0] den,
    output logic      [Q_W-1:0]          quot
);
    import btpr_pkg::*;

    logic [THR_W-1:0] rem_reg [Q_W];
    logic [THR_W-1:0] den_reg [Q_W];
    logic [Q_W-1:0]   q_reg   [Q_W];

    for (genvar s = 0; s < Q_W; s++)
    begin : g_step
        logic [THR_W-1:0] rem_in;
        logic [THR_W-1:0] den_in;
        logic [Q_W-1:0]   q_in;
        logic [THR_W:0]   rem_sh;
        logic [THR_W:0]   diff;

        if (s == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign q_in   = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
            assign q_in   = q_reg[s-1];
        end

        assign rem_sh = {rem_in, 1'b0};
        assign diff   = rem_sh - {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[s] <= den_in;
                if (rem_sh >= {1'b0, den_in})
                begin
                    rem_reg[s] <= diff[THR_W-1:0];
                    q_reg[s]   <= {q_in[Q_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[s] <= rem_sh[THR_W-1:0];
                    q_reg[s]   <= {q_in[Q_W-2:0], 1'b0};
                end
            end
        end
    end

    assign quot = q_reg[Q_W-1];
endmodule
`default_nettype wire

[sv/btpr_cordic.sv]
// Pipelined vectoring CORDIC giving atan2(y, x) for x >= 0 in 1/256 degree, clamped.
// Depends on btpr_pkg for widths and the angle table.
`default_nettype none
module btpr_cordic #(
    parameter int STAGES = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  en,
    input  wire logic signed [btpr_pkg::CORDIC_W-1:0] y_in,
    input  wire logic signed [btpr_pkg::CORDIC_W-1:0] x_in,
    output logic signed      [btpr_pkg::ANGLE_W-1:0]  angle
);
    import btpr_pkg::*;

    localparam int RUN = (STAGES < ATAN_ENTRIES) ? STAGES : ATAN_ENTRIES;
    localparam logic signed [Z_W-1:0] LIM_P = Z_W'(ANGLE_LIMIT);
    localparam logic signed [Z_W-1:0] LIM_N = -Z_W'(ANGLE_LIMIT);

    logic signed [CORDIC_W-1:0] x_reg [RUN];
    logic signed [CORDIC_W-1:0] y_reg [RUN];
    logic signed [Z_W-1:0]      z_reg [RUN];
    logic signed [ANGLE_W-1:0]  angle_reg;

    for (genvar s = 0; s < RUN; s++)
    begin : g_stage
        localparam logic signed [Z_W-1:0] ATAN_S = atan_q16(s);
        logic signed [CORDIC_W-1:0] x_prev;
        logic signed [CORDIC_W-1:0] y_prev;
        logic signed [Z_W-1:0]      z_prev;
        logic signed [CORDIC_W-1:0] dx;
        logic signed [CORDIC_W-1:0] dy;

        if (s == 0)
        begin : g_first
            assign x_prev = x_in;
            assign y_prev = y_in;
            assign z_prev = '0;
        end
        else
        begin : g_next
            assign x_prev = x_reg[s-1];
            assign y_prev = y_reg[s-1];
            assign z_prev = z_reg[s-1];
        end

        assign dx = y_prev >>> s;
        assign dy = x_prev >>> s;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!y_prev[CORDIC_W-1])
                begin
                    x_reg[s] <= x_prev + dx;
                    y_reg[s] <= y_prev - dy;
                    z_reg[s] <= z_prev + ATAN_S;
                end
                else
                begin
                    x_reg[s] <= x_prev - dx;
                    y_reg[s] <= y_prev + dy;
                    z_reg[s] <= z_prev - ATAN_S;
                end
            end
        end
    end

    logic signed [Z_W-1:0] z_round;

    // Q16 degrees to 1/256 degree, rounding half up.
    assign z_round = (z_reg[RUN-1] + Z_W'(128)) >>> 8;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (z_round > LIM_P)
            begin
                angle_reg <= LIM_P[ANGLE_W-1:0];
            end
            else if (z_round < LIM_N)
            begin
                angle_reg <= LIM_N[ANGLE_W-1:0];
            end
            else
            begin
                angle_reg <= z_round[ANGLE_W-1:0];
            end
        end
    end

    assign angle = angle_reg;
endmodule
`default_nettype wire

[sv/blended_tilt_pitch_roll.sv]
// Blended tilt pitch and roll pipeline.
// Throughput one transaction per cycle; the whole pipeline advances together and
// holds while a finished result waits. Depth is set by the two square-root chains
// (16 and 28 steps), the 12-step weight divider and the CORDIC stages.
// Reset empties the pipeline and loads the register defaults.
`default_nettype none
module blended_tilt_pitch_roll #(
    parameter int CORDIC_STAGES = btpr_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [btpr_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  wire logic [btpr_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic signed [btpr_pkg::VEC_W-1:0]  accel_x,
    input  wire logic signed [btpr_pkg::VEC_W-1:0]  accel_y,
    input  wire logic signed [btpr_pkg::VEC_W-1:0]  accel_z,
    input  wire logic signed [btpr_pkg::VEC_W-1:0]  grav_x,
    input  wire logic signed [btpr_pkg::VEC_W-1:0]  grav_y,
    input  wire logic signed [btpr_pkg::VEC_W-1:0]  grav_z,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [btpr_pkg::ANGLE_W-1:0]     pitch,
    output logic signed [btpr_pkg::ANGLE_W-1:0]     roll,
    output logic        [btpr_pkg::W_W-1:0]         blend_weight,
    output logic        [btpr_pkg::MAG_W-1:0]       accel_magnitude,
    output logic        [btpr_pkg::MAG_W-1:0]       gravity_magnitude,
    output logic        [btpr_pkg::MAG_W-1:0]       norm_error,
    output logic                                    valid_res
);
    import btpr_pkg::*;

    localparam int CORDIC_RUN = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
    localparam int K_MAG   = 2 + SQRT_A_STEPS;
    localparam int K_T3    = K_MAG + 1;
    localparam int K_Q     = K_T3 + DIV_STEPS;
    localparam int K_W     = K_Q + 1;
    localparam int K_H     = K_W + 2;
    localparam int K_SUM   = K_H + 2;
    localparam int K_VLD   = K_SUM + 1;
    localparam int K_R     = K_SUM + SQRT_H_STEPS;
    localparam int K_ANG   = K_R + CORDIC_RUN + 1;
    localparam int LATENCY = K_ANG + 1;

    // Configuration registers.
    logic [THR_W-1:0] nominal_reg, err_low_reg, err_high_reg;
    logic [LIM_W-1:0] grav_min_reg, grav_max_reg, min_norm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nominal_reg  <= NOMINAL_RST;
            err_low_reg  <= ERR_LOW_RST;
            err_high_reg <= ERR_HIGH_RST;
            grav_min_reg <= GRAV_MIN_RST;
            grav_max_reg <= GRAV_MAX_RST;
            min_norm_reg <= MIN_NORM_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_NOMINAL:  nominal_reg  <= cfg_data[THR_W-1:0];
                CFG_ERR_LOW:  err_low_reg  <= cfg_data[THR_W-1:0];
                CFG_ERR_HIGH: err_high_reg <= cfg_data[THR_W-1:0];
                CFG_GRAV_MIN: grav_min_reg <= cfg_data;
                CFG_GRAV_MAX: grav_max_reg <= cfg_data;
                CFG_MIN_NORM: min_norm_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Pipeline advance and valid chain.
    logic               adv;
    logic [LATENCY-1:0] vld_reg;

    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LATENCY-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[LATENCY-1];

    // Stage 1 and 2: squares and sums of both input vectors.
    logic signed [VEC_W-1:0] a_vec [3];
    logic signed [VEC_W-1:0] g_vec [3];
    logic signed [31:0]      a_sq [3];
    logic signed [31:0]      g_sq [3];
    logic [SQ_W-1:0]         asq_reg [3];
    logic [SQ_W-1:0]         gsq_reg [3];
    logic [ASUM_W-1:0]       asum_reg, gsum_reg;

    assign a_vec[0] = accel_x;
    assign a_vec[1] = accel_y;
    assign a_vec[2] = accel_z;
    assign g_vec[0] = grav_x;
    assign g_vec[1] = grav_y;
    assign g_vec[2] = grav_z;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            a_sq[k] = 32'(a_vec[k]) * 32'(a_vec[k]);
            g_sq[k] = 32'(g_vec[k]) * 32'(g_vec[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                asq_reg[k] <= a_sq[k][SQ_W-1:0];
                gsq_reg[k] <= g_sq[k][SQ_W-1:0];
            end
            asum_reg <= ASUM_W'(asq_reg[0]) + ASUM_W'(asq_reg[1]) + ASUM_W'(asq_reg[2]);
            gsum_reg <= ASUM_W'(gsq_reg[0]) + ASUM_W'(gsq_reg[1]) + ASUM_W'(gsq_reg[2]);
        end
    end

    logic [MAG_W-1:0] amag, gmag;

    btpr_isqrt #(.IN_W(ASUM_W)) u_sqrt_a (
        .clk(clk), .en(adv), .radicand(asum_reg), .root(amag)
    );
    btpr_isqrt #(.IN_W(ASUM_W)) u_sqrt_g (
        .clk(clk), .en(adv), .radicand(gsum_reg), .root(gmag)
    );

    // Error from nominal gravity and the weight decisions.
    logic [MAG_W-1:0] err;
    logic [MAG_W-1:0] err_reg, amag_reg, gmag_reg;
    logic [THR_W-1:0] num_reg, den_reg;
    wflags_t          flags_reg, flags_d;

    assign err = (amag >= {1'b0, nominal_reg}) ? amag - {1'b0, nominal_reg}
                                               : {1'b0, nominal_reg} - amag;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            err_reg        <= err;
            amag_reg       <= amag;
            gmag_reg       <= gmag;
            flags_reg.le   <= err <= {1'b0, err_low_reg};
            flags_reg.ge   <= err >= {1'b0, err_high_reg};
            flags_reg.gout <= (gmag < grav_min_reg) || (gmag > grav_max_reg);
            // Only used on the ramp, where the error is below the high threshold.
            num_reg        <= err_high_reg - err[THR_W-1:0];
            den_reg        <= err_high_reg - err_low_reg;
        end
    end

    logic [DIV_STEPS-1:0] quot;

    btpr_div #(.Q_W(DIV_STEPS)) u_div (
        .clk(clk), .en(adv), .num(num_reg), .den(den_reg), .quot(quot)
    );

    btpr_delay #(.W($bits(wflags_t)), .DEPTH(DIV_STEPS)) u_dly_flags (
        .clk(clk), .en(adv), .din(flags_reg), .dout(flags_d)
    );

    logic [W_W-1:0] w_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (flags_d.gout || flags_d.le)
            begin
                w_reg <= W_ONE;
            end
            else if (flags_d.ge)
            begin
                w_reg <= '0;
            end
            else
            begin
                w_reg <= W_W'(quot);
            end
        end
    end

    // Blend of the two vectors, Q12 scaled.
    logic [6*VEC_W-1:0]      ag_d;
    logic signed [VEC_W-1:0] a_d [3];
    logic signed [VEC_W-1:0] g_d [3];

    btpr_delay #(.W(6*VEC_W), .DEPTH(K_W)) u_dly_vec (
        .clk(clk), .en(adv),
        .din({accel_x, accel_y, accel_z, grav_x, grav_y, grav_z}),
        .dout(ag_d)
    );

    assign a_d[0] = ag_d[6*VEC_W-1 -: VEC_W];
    assign a_d[1] = ag_d[5*VEC_W-1 -: VEC_W];
    assign a_d[2] = ag_d[4*VEC_W-1 -: VEC_W];
    assign g_d[0] = ag_d[3*VEC_W-1 -: VEC_W];
    assign g_d[1] = ag_d[2*VEC_W-1 -: VEC_W];
    assign g_d[2] = ag_d[VEC_W-1 -: VEC_W];

    logic signed [W_W:0]     w_s, wg_s;
    logic signed [PROD_W-1:0] pa_reg [3];
    logic signed [PROD_W-1:0] pg_reg [3];
    logic signed [H_W-1:0]    h_reg [3];
    logic signed [PROD_W:0]   h_full [3];

    assign w_s  = $signed({1'b0, w_reg});
    assign wg_s = $signed({1'b0, W_ONE - w_reg});

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            h_full[k] = (PROD_W+1)'(pa_reg[k]) + (PROD_W+1)'(pg_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pa_reg[k] <= PROD_W'(w_s) * PROD_W'(a_d[k]);
                pg_reg[k] <= PROD_W'(wg_s) * PROD_W'(g_d[k]);
                h_reg[k]  <= h_full[k][H_W-1:0];
            end
        end
    end

    // Squares of the blended vector, partial sums and the norm test.
    logic [HABS_W-1:0]   habs [3];
    logic [HSQ_W-1:0]    hsq_reg [3];
    logic [NORM2_W-1:0]  norm2_reg;
    logic [HSQ_W-1:0]    sxz_reg, syz_reg;
    logic [HSUM_W-1:0]   hsum_reg;
    logic                hok_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            habs[k] = h_reg[k][H_W-1] ? HABS_W'(-h_reg[k]) : HABS_W'(h_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                hsq_reg[k] <= HSQ_W'(habs[k]) * HSQ_W'(habs[k]);
            end
            norm2_reg <= NORM2_W'(min_norm_reg) * NORM2_W'(min_norm_reg);
            sxz_reg   <= hsq_reg[0] + hsq_reg[2];
            syz_reg   <= hsq_reg[1] + hsq_reg[2];
            hsum_reg  <= HSUM_W'(hsq_reg[0]) + HSUM_W'(hsq_reg[1]) + HSUM_W'(hsq_reg[2]);
            hok_reg   <= hsum_reg >= HSUM_W'({norm2_reg, {NORM_SHIFT{1'b0}}});
        end
    end

    logic [HABS_W-1:0] rxz, ryz;

    btpr_isqrt #(.IN_W(HSQ_W)) u_sqrt_xz (
        .clk(clk), .en(adv), .radicand(sxz_reg), .root(rxz)
    );
    btpr_isqrt #(.IN_W(HSQ_W)) u_sqrt_yz (
        .clk(clk), .en(adv), .radicand(syz_reg), .root(ryz)
    );

    logic [2*H_W-1:0]     hxy_d;
    logic signed [H_W-1:0] hx_d, hy_d;

    btpr_delay #(.W(2*H_W), .DEPTH(K_R - K_H)) u_dly_h (
        .clk(clk), .en(adv), .din({h_reg[0], h_reg[1]}), .dout(hxy_d)
    );

    assign hx_d = hxy_d[2*H_W-1 -: H_W];
    assign hy_d = hxy_d[H_W-1:0];

    // Both angle operands scaled by 256.
    logic signed [CORDIC_W-1:0] p_y, p_x, r_y, r_x;
    logic signed [ANGLE_W-1:0]  pitch_c, roll_c;

    assign p_y = CORDIC_W'(hy_d) <<< 8;
    assign r_y = CORDIC_W'(hx_d) <<< 8;
    assign p_x = $signed({{(CORDIC_W-HABS_W-8){1'b0}}, rxz, 8'b0});
    assign r_x = $signed({{(CORDIC_W-HABS_W-8){1'b0}}, ryz, 8'b0});

    btpr_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_pitch (
        .clk(clk), .en(adv), .y_in(p_y), .x_in(p_x), .angle(pitch_c)
    );
    btpr_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_roll (
        .clk(clk), .en(adv), .y_in(r_y), .x_in(r_x), .angle(roll_c)
    );

    // Side fields brought level with the angles.
    logic [3*MAG_W-1:0] mag_d;
    logic [W_W-1:0]     w_d;
    logic               hok_d;

    btpr_delay #(.W(3*MAG_W), .DEPTH(K_ANG - K_T3)) u_dly_mag (
        .clk(clk), .en(adv), .din({amag_reg, gmag_reg, err_reg}), .dout(mag_d)
    );
    btpr_delay #(.W(W_W), .DEPTH(K_ANG - K_W)) u_dly_w (
        .clk(clk), .en(adv), .din(w_reg), .dout(w_d)
    );
    btpr_delay #(.W(1), .DEPTH(K_ANG - K_VLD)) u_dly_ok (
        .clk(clk), .en(adv), .din(hok_reg), .dout(hok_d)
    );

    // Output register; a short blended vector clears every field.
    logic signed [ANGLE_W-1:0] pitch_reg, roll_reg;
    logic [W_W-1:0]            weight_reg;
    logic [MAG_W-1:0]          amag_o_reg, gmag_o_reg, err_o_reg;
    logic                      ok_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ok_reg     <= hok_d;
            pitch_reg  <= hok_d ? pitch_c : '0;
            roll_reg   <= hok_d ? roll_c : '0;
            weight_reg <= hok_d ? w_d : '0;
            amag_o_reg <= hok_d ? mag_d[3*MAG_W-1 -: MAG_W] : '0;
            gmag_o_reg <= hok_d ? mag_d[2*MAG_W-1 -: MAG_W] : '0;
            err_o_reg  <= hok_d ? mag_d[MAG_W-1:0] : '0;
        end
    end

    assign pitch             = pitch_reg;
    assign roll              = roll_reg;
    assign blend_weight      = weight_reg;
    assign accel_magnitude   = amag_o_reg;
    assign gravity_magnitude = gmag_o_reg;
    assign norm_error        = err_o_reg;
    assign valid_res         = ok_reg;

`include "assert_macros.svh"

    `BTPR_ASSERT_IMPL(a_invalid_zero, out_valid && !valid_res, pitch == '0 && roll == '0 && blend_weight == '0 && accel_magnitude == '0 && gravity_magnitude == '0 && norm_error == '0)
    `BTPR_ASSERT_IMPL(a_weight_range, out_valid && valid_res, blend_weight <= W_ONE)
    `BTPR_ASSERT_IMPL(a_angle_range, out_valid, $signed(pitch) <= 16'sd23040 && $signed(pitch) >= -16'sd23040 && $signed(roll) <= 16'sd23040 && $signed(roll) >= -16'sd23040)
    `BTPR_ASSERT_NEXT(a_stall_keeps_result, !in_ready, out_valid)

endmodule
`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for blended_tilt_pitch_roll: directed table, then random items.
// Depends on btpr_pkg and the blended_tilt_pitch_roll RTL; predicts every result itself.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import btpr_pkg::*;

    typedef struct {
        logic signed [15:0] ax, ay, az, gx, gy, gz;
    } tilt_in_t;

    typedef struct {
        logic signed [15:0] pitch, roll;
        logic [12:0] weight;
        logic [15:0] amag, gmag, aerr;
        logic        ok;
    } tilt_out_t;

    typedef struct {
        tilt_in_t  vec;
        logic      known;
        tilt_out_t res;
    } table_row_t;

    logic clk, rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0] cfg_data;
    logic in_valid, in_ready, out_valid, out_ready;
    logic signed [15:0] accel_x, accel_y, accel_z, grav_x, grav_y, grav_z;
    logic signed [15:0] pitch, roll;
    logic [12:0] blend_weight;
    logic [15:0] accel_magnitude, gravity_magnitude, norm_error;
    logic valid_res;

    blended_tilt_pitch_roll dut (.*);

    // Model copy of the register file.
    longint nom_g, e_low, e_high, g_min, g_max, min_norm;
    tilt_out_t expected_q[$];
    int errors = 0;
    int send_idle = 0;
    int recv_stall = 0;
    bit hold_off = 0;

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial begin
        #50_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < CORDIC_STAGES_DEF && i < ATAN_ENTRIES; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y >= 0)
            begin
                x += dx; y -= dy; z += longint'(atan_q16(i));
            end
            else
            begin
                x -= dx; y += dy; z -= longint'(atan_q16(i));
            end
        end
        z = floor_shift(z + 128, 8);
        if (z > ANGLE_LIMIT) z = ANGLE_LIMIT;
        if (z < -ANGLE_LIMIT) z = -ANGLE_LIMIT;
        return z;
    endfunction

    function automatic tilt_out_t predict_tilt(tilt_in_t v);
        tilt_out_t o;
        longint a[3], g[3], h[3];
        longint amag, gmag, err, w, lim, rxz, ryz;
        longint unsigned hsum;
        a[0] = v.ax; a[1] = v.ay; a[2] = v.az;
        g[0] = v.gx; g[1] = v.gy; g[2] = v.gz;
        amag = int_sqrt(a[0]*a[0] + a[1]*a[1] + a[2]*a[2]);
        gmag = int_sqrt(g[0]*g[0] + g[1]*g[1] + g[2]*g[2]);
        err = (amag >= nom_g) ? amag - nom_g : nom_g - amag;
        if (err <= e_low) w = 4096;
        else if (err >= e_high) w = 0;
        else w = ((e_high - err) * 4096) / (e_high - e_low);
        if (gmag < g_min || gmag > g_max) w = 4096;
        for (int k = 0; k < 3; k++) h[k] = w * a[k] + (4096 - w) * g[k];
        hsum = h[0]*h[0] + h[1]*h[1] + h[2]*h[2];
        lim = min_norm * 4096;
        o = '{default: '0};
        if (hsum < longint'(lim) * lim) return o;
        rxz = int_sqrt(h[0]*h[0] + h[2]*h[2]);
        ryz = int_sqrt(h[1]*h[1] + h[2]*h[2]);
        o.pitch = 16'(vector_angle(h[1] * 256, rxz * 256));
        o.roll = 16'(vector_angle(h[0] * 256, ryz * 256));
        o.weight = 13'(w);
        o.amag = 16'(amag);
        o.gmag = 16'(gmag);
        o.aerr = 16'(err);
        o.ok = 1'b1;
        return o;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= CFG_W'(val);
        case (idx)
            CFG_NOMINAL:  nom_g = val & 16'h7FFF;
            CFG_ERR_LOW:  e_low = val & 16'h7FFF;
            CFG_ERR_HIGH: e_high = val & 16'h7FFF;
            CFG_GRAV_MIN: g_min = val & 16'hFFFF;
            CFG_GRAV_MAX: g_max = val & 16'hFFFF;
            CFG_MIN_NORM: min_norm = val & 16'hFFFF;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_regs(longint n, longint lo, longint hi, longint gn, longint gx,
                             longint mn);
        write_reg(CFG_NOMINAL, n);
        write_reg(CFG_ERR_LOW, lo);
        write_reg(CFG_ERR_HIGH, hi);
        write_reg(CFG_GRAV_MIN, gn);
        write_reg(CFG_GRAV_MAX, gx);
        write_reg(CFG_MIN_NORM, mn);
    endtask

    // Offers one transaction and returns at the falling edge after it has been accepted.
    // Valid stays high into the next transaction unless an idle gap is drawn.
    task automatic send_sample(tilt_in_t v);
        int gap;
        gap = (send_idle > 0 && $urandom_range(99) < send_idle) ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        accel_x <= v.ax; accel_y <= v.ay; accel_z <= v.az;
        grav_x <= v.gx; grav_y <= v.gy; grav_z <= v.gz;
        in_valid <= 1'b1;
        expected_q.push_back(predict_tilt(v));
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_axis();
        case ($urandom_range(5))
            0: return 16'($urandom);
            1: return 16'sd32767;
            2: return -16'sd32768;
            default: return 16'($signed($urandom_range(1600)) - 800);
        endcase
    endfunction

    // Mostly near one g in total, so the weight ramp and the window are reached.
    function automatic tilt_in_t rand_sample();
        tilt_in_t v;
        v.ax = rand_axis(); v.ay = rand_axis(); v.az = rand_axis();
        if ($urandom_range(3) != 0)
        begin
            v.az = 16'($signed($urandom_range(2600, 1800)));
            if ($urandom_range(1)) v.az = -v.az;
        end
        if ($urandom_range(2) == 0)
        begin
            v.gx = rand_axis(); v.gy = rand_axis(); v.gz = rand_axis();
        end
        else
        begin
            v.gx = 16'($signed($urandom_range(600)) - 300);
            v.gy = 16'($signed($urandom_range(600)) - 300);
            v.gz = 16'($signed($urandom_range(2700, 2300)));
            if ($urandom_range(1)) v.gz = -v.gz;
        end
        return v;
    endfunction

    // Result checker.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%t: unexpected result, expected none, actual pitch %0d", $time,
                         pitch);
                errors++;
            end
            else
            begin
                tilt_out_t e;
                e = expected_q.pop_front();
                if (pitch !== e.pitch || roll !== e.roll || blend_weight !== e.weight ||
                    accel_magnitude !== e.amag || gravity_magnitude !== e.gmag ||
                    norm_error !== e.aerr || valid_res !== e.ok)
                begin
                    $display("%t: mismatch expected p=%0d r=%0d w=%0d am=%0d gm=%0d er=%0d v=%0b",
                             $time, e.pitch, e.roll, e.weight, e.amag, e.gmag, e.aerr, e.ok);
                    $display("%t:          actual p=%0d r=%0d w=%0d am=%0d gm=%0d er=%0d v=%0b",
                             $time, pitch, roll, blend_weight, accel_magnitude,
                             gravity_magnitude, norm_error, valid_res);
                    errors++;
                end
            end
        end
    end

    // Receiver readiness, with a long hold-off on request.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_ready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_off = 0;
            end
            out_ready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
        end
    end

    initial
    begin
        table_row_t rows[$];
        tilt_out_t zero;
        tilt_in_t v;
        int phase;
        zero = '{default: '0};
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0; in_valid = 1'b0;
        accel_x = 0; accel_y = 0; accel_z = 0; grav_x = 0; grav_y = 0; grav_z = 0;
        nom_g = NOMINAL_RST; e_low = ERR_LOW_RST; e_high = ERR_HIGH_RST;
        g_min = GRAV_MIN_RST; g_max = GRAV_MAX_RST; min_norm = MIN_NORM_RST;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // All-zero vectors fall below the minimum blended norm.
        rows.push_back('{'{0, 0, 0, 0, 0, 0}, 1'b1, zero});
        rows.push_back('{'{0, 0, 2511, 0, 0, 2511}, 1'b0, zero});
        rows.push_back('{'{0, 2511, 0, 0, 0, 2511}, 1'b0, zero});
        rows.push_back('{'{2511, 0, 0, 0, 0, -2511}, 1'b0, zero});
        rows.push_back('{'{0, -2511, 0, 0, 0, 2511}, 1'b0, zero});
        rows.push_back('{'{32767, 32767, 32767, 32767, 32767, 32767}, 1'b0, zero});
        rows.push_back('{'{-32768, -32768, -32768, -32768, -32768, -32768}, 1'b0, zero});
        rows.push_back('{'{-32768, 32767, -32768, 0, 0, 2511}, 1'b0, zero});
        rows.push_back('{'{0, 0, 2700, 100, 100, 2500}, 1'b0, zero});
        rows.push_back('{'{0, 0, 2200, 100, -100, 2500}, 1'b0, zero});
        rows.push_back('{'{300, 200, 2400, 0, 0, 1000}, 1'b0, zero});
        rows.push_back('{'{1, 0, 0, 0, 0, 0}, 1'b0, zero});
        rows.push_back('{'{0, 0, 25, 0, 0, 0}, 1'b0, zero});
        rows.push_back('{'{0, 0, 26, 0, 0, 0}, 1'b0, zero});
        rows.push_back('{'{0, 0, 2600, 0, 0, -2600}, 1'b0, zero});
        foreach (rows[i])
        begin
            send_sample(rows[i].vec);
            if (rows[i].known) expected_q[$] = rows[i].res;
        end
        drain();

        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: load_regs(2511, 51, 384, 2048, 2944, 26);
                1: load_regs(32767, 32767, 32767, 65535, 65535, 65535);
                2: load_regs(0, 0, 0, 0, 0, 0);
                3: load_regs(2511, 400, 100, 0, 65535, 1);
                4: load_regs(2400, 10, 2000, 1500, 3500, 500);
                default: load_regs($urandom_range(32767), $urandom_range(300),
                                   $urandom_range(3000), $urandom_range(2400),
                                   $urandom_range(65535, 2400), $urandom_range(2000));
            endcase
            case (phase % 4)
                0: begin send_idle = 0; recv_stall = 0; end
                1: begin send_idle = 82; recv_stall = 0; end
                2: begin send_idle = 0; recv_stall = 82; end
                default: begin send_idle = 26; recv_stall = 26; end
            endcase
            if (phase == 0) hold_off = 1;
            repeat (280)
            begin
                v = rand_sample();
                send_sample(v);
            end
            drain();
        end

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire

[filelist.f]
+incdir+sv
sv/btpr_pkg.sv
sv/btpr_delay.sv
sv/btpr_isqrt.sv
sv/btpr_div.sv
sv/btpr_cordic.sv
sv/blended_tilt_pitch_roll.sv
bench/tb_top.sv
